>>> sv/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Entry and result word layouts, operation and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic signed [31:0] data;
      logic [7:0]         pri;
   } entry_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               top_valid;
      logic signed [31:0] top_data;
      logic [7:0]         top_priority;
      logic [3:0]         entry_count;
   } result_type;

endpackage

>>> sv/spq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_mem: entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  spq_pkg::entry_type  wr_entry,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output spq_pkg::entry_type  rd_entry
);
   import spq_pkg::*;

   entry_type entry_mem_ff [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

>>> sv/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: insertion sequencer
// Walks the sorted store one entry per step with a single priority compare,
// shifting entries up until the new entry's place is found.
// ----------------------------------------------------------------------------
module spq_ctrl #(
   parameter int DEPTH = 8,
   parameter int AW    = 3,
   parameter int CW    = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic signed [31:0]   req_item_data,
   input  logic [7:0]           req_item_priority,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output spq_pkg::entry_type   wr_entry,
   output logic                 rd_en,
   output logic [AW-1:0]        rd_addr,
   input  spq_pkg::entry_type   rd_entry,
   output logic                 res_valid,
   input  logic                 res_ready,
   output spq_pkg::result_type  res
);
   import spq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_RD,
      S_SHIFT_CMP,
      S_PLACE,
      S_TOP_RD,
      S_RESULT
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   pos_ff, pos_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic [1:0]      status_ff, status_in;
   entry_type       new_ff, new_in;

   logic [CW-1:0]   pos_dec;
   logic [CW-1:0]   fill_dec;
   logic [CW-1:0]   fill_inc;
   logic [CW+3:0]   count_ext;
   logic            accept;
   entry_type       req_entry;

   assign pos_dec   = pos_ff - 1'b1;
   assign fill_dec  = fill_ff - 1'b1;
   assign fill_inc  = fill_ff + 1'b1;
   assign count_ext = {4'd0, fill_ff};
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_entry = '{data: req_item_data, pri: req_item_priority};

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      fill_in   = fill_ff;
      status_in = status_ff;
      new_in    = new_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff[AW-1:0];
      wr_entry  = new_ff;
      rd_en     = 1'b0;
      rd_addr   = pos_dec[AW-1:0];
      res_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               new_in    = req_entry;
               status_in = ST_DONE;
               state_in  = S_TOP_RD;
               if (req_operation == OP_INSERT) begin
                  if (fill_ff == CW'(DEPTH)) begin
                     status_in = ST_OVERFLOW;
                  end else if (fill_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_entry = req_entry;
                     fill_in  = fill_inc;
                  end else begin
                     pos_in   = fill_ff;
                     state_in = S_SHIFT_RD;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     fill_in = fill_dec;
                  end
               end
            end
         end
         S_SHIFT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = pos_dec[AW-1:0];
            state_in = S_SHIFT_CMP;
         end
         S_SHIFT_CMP: begin
            wr_en = 1'b1;
            if (rd_entry.pri >= new_ff.pri) begin
               wr_entry = rd_entry;
               pos_in   = pos_dec;
               state_in = (pos_dec == '0) ? S_PLACE : S_SHIFT_RD;
            end else begin
               fill_in  = fill_inc;
               state_in = S_TOP_RD;
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            fill_in  = fill_inc;
            state_in = S_TOP_RD;
         end
         S_TOP_RD: begin
            rd_en    = (fill_ff != '0);
            rd_addr  = fill_dec[AW-1:0];
            state_in = S_RESULT;
         end
         S_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      res.status       = status_ff;
      res.top_valid    = (fill_ff != '0);
      res.top_data     = res.top_valid ? rd_entry.data : 32'sd0;
      res.top_priority = res.top_valid ? rd_entry.pri : 8'd0;
      res.entry_count  = count_ext[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         pos_ff    <= '0;
         status_ff <= ST_DONE;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         pos_ff    <= pos_in;
         status_ff <= status_in;
      end
      new_ff <= new_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == OP_INSERT && fill_ff == CW'(DEPTH)
      |=> fill_ff == $past(fill_ff) && status_ff == ST_OVERFLOW)
      else $error("overflow insert changed the fill count");

   a_underflow_hold: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == OP_REMOVE && fill_ff == '0
      |=> fill_ff == '0 && status_ff == ST_UNDERFLOW)
      else $error("underflow remove changed the fill count");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(res))
      else $error("pending result changed before hand-off");

endmodule

>>> sv/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue on a sorted entry store
// Usage:
//   req_ channel carries one word per operation: insert (data, priority) or
//   remove the highest-priority entry. rsp_ channel returns one word per
//   operation: status, the top entry after the operation, and the count.
//   Entries of equal priority leave in arrival order.
//   A remove, an overflow or an insert into an empty queue goes straight to
//   the top read; an insert into a non-empty queue first shifts entries up,
//   with an extra place step when all entries move up. Each shifted entry
//   costs one read and one compare-and-write on the single store port pair.
//   With rsp_stall low the next word is accepted in the cycle after the
//   result is handed off.
//   One operation is in progress at a time; req_stall is high from the cycle
//   after acceptance until the result has been handed to the output register.
//   The output register holds a result while rsp_stall is high, and the next
//   operation may be accepted meanwhile; its result waits until the slot frees.
//   Reset empties the queue and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_operation,
   input  logic signed [31:0]  req_item_data,
   input  logic [7:0]          req_item_priority,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic                rsp_top_valid,
   output logic signed [31:0]  rsp_top_data,
   output logic [7:0]          rsp_top_priority,
   output logic [3:0]          rsp_entry_count
);
   import spq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_entry;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_entry;
   logic          res_valid;
   logic          res_ready;
   result_type    res;

   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff, rsp_in;

   spq_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   spq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_entry          (wr_entry),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_entry          (rd_entry),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res               (res)
   );

   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_top_valid    = rsp_ff.top_valid;
   assign rsp_top_data     = rsp_ff.top_data;
   assign rsp_top_priority = rsp_ff.top_priority;
   assign rsp_entry_count  = rsp_ff.entry_count;

endmodule

>>> dv/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// A directed table covers empty and full queues, priority extremes and ties.
// It is followed by random insert/remove runs with a drifting insert bias.
// Every result word is compared field by field with an expected word: written in
// the table for fixed rows, else from an in-bench queue model. Both channels idle
// at random, with one stretch that runs flat out.
module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH   = 8;
   localparam int RANDOM_WORDS  = 1650;
   localparam int STALL_PCT     = 35;
   localparam int CALM_FIRST    = 700;
   localparam int CALM_LAST     = 1000;
   localparam int DRAIN_CYCLES  = 2 * QUEUE_DEPTH + 8;
   localparam int WATCHDOG_MAX  = 4000;

   typedef struct packed {
      bit                 fixed;
      result_type         want;
      logic               op;
      logic signed [31:0] data;
      logic [7:0]         pri;
   } stim_row_type;

   localparam result_type NO_RESULT = '0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = OP_INSERT;
   logic signed [31:0] req_item_data = '0;
   logic [7:0]         req_item_priority = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic               rsp_top_valid;
   logic signed [31:0] rsp_top_data;
   logic [7:0]         rsp_top_priority;
   logic [3:0]         rsp_entry_count;

   stim_row_type       stimulus[$];
   result_type         expected_results[$];
   logic signed [31:0] model_data[QUEUE_DEPTH];
   logic [7:0]         model_pri[QUEUE_DEPTH];
   int                 model_fill = 0;
   int                 error_count = 0;
   int                 words_checked = 0;
   int                 quiet_cycles = 0;

   sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_top_valid     (rsp_top_valid),
      .rsp_top_data      (rsp_top_data),
      .rsp_top_priority  (rsp_top_priority),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH word %0d: %s", words_checked, msg);
      error_count++;
   endtask

   task automatic add_row(input logic op, input logic signed [31:0] data,
                          input logic [7:0] pri, input bit fixed,
                          input result_type want);
      stim_row_type row;
      row.fixed = fixed;
      row.want  = want;
      row.op    = op;
      row.data  = data;
      row.pri   = pri;
      stimulus.push_back(row);
   endtask

   // apply one operation to the model queue and return the word it yields
   function automatic result_type queue_step(input logic op,
                                             input logic signed [31:0] data,
                                             input logic [7:0] pri);
      result_type res;
      int pos;
      res = '0;
      res.status = ST_DONE;
      if (op == OP_INSERT) begin
         if (model_fill >= QUEUE_DEPTH) begin
            res.status = ST_OVERFLOW;
         end else begin
            pos = model_fill;
            while (pos > 0 && model_pri[pos - 1] >= pri) begin
               model_data[pos] = model_data[pos - 1];
               model_pri[pos]  = model_pri[pos - 1];
               pos--;
            end
            model_data[pos] = data;
            model_pri[pos]  = pri;
            model_fill++;
         end
      end else begin
         if (model_fill == 0)
            res.status = ST_UNDERFLOW;
         else
            model_fill--;
      end
      if (model_fill > 0) begin
         res.top_valid    = 1'b1;
         res.top_data     = model_data[model_fill - 1];
         res.top_priority = model_pri[model_fill - 1];
      end
      res.entry_count = 4'(model_fill);
      return res;
   endfunction

   task automatic build_stimulus();
      int insert_pct;
      int mode;
      logic [7:0] pri;
      add_row(OP_REMOVE, 32'sd0, 8'd0, 1'b1,
              '{status: ST_UNDERFLOW, top_valid: 1'b0, top_data: 32'sd0,
                top_priority: 8'd0, entry_count: 4'd0});
      add_row(OP_INSERT, 32'h7FFF_FFFF, 8'd255, 1'b1,
              '{status: ST_DONE, top_valid: 1'b1, top_data: 32'h7FFF_FFFF,
                top_priority: 8'd255, entry_count: 4'd1});
      add_row(OP_INSERT, 32'h8000_0000, 8'd0, 1'b1,
              '{status: ST_DONE, top_valid: 1'b1, top_data: 32'h7FFF_FFFF,
                top_priority: 8'd255, entry_count: 4'd2});
      add_row(OP_INSERT, 32'hFFFF_FFFF, 8'd255, 1'b0, NO_RESULT);
      add_row(OP_INSERT, 32'sd5,        8'd128, 1'b0, NO_RESULT);
      add_row(OP_INSERT, 32'sd0,        8'd0,   1'b0, NO_RESULT);
      add_row(OP_INSERT, -32'sd2,       8'd255, 1'b0, NO_RESULT);
      add_row(OP_INSERT, 32'sd1,        8'd1,   1'b0, NO_RESULT);
      add_row(OP_INSERT, 32'sd3,        8'd254, 1'b0, NO_RESULT);
      add_row(OP_INSERT, 32'h5555_AAAA, 8'd77, 1'b1,
              '{status: ST_OVERFLOW, top_valid: 1'b1, top_data: 32'h7FFF_FFFF,
                top_priority: 8'd255, entry_count: 4'd8});
      repeat (QUEUE_DEPTH)
         add_row(OP_REMOVE, $urandom, 8'($urandom), 1'b0, NO_RESULT);
      add_row(OP_REMOVE, 32'hFFFF_FFFF, 8'd255, 1'b1,
              '{status: ST_UNDERFLOW, top_valid: 1'b0, top_data: 32'sd0,
                top_priority: 8'd0, entry_count: 4'd0});
      add_row(OP_INSERT, 32'sd0, 8'd0, 1'b0, NO_RESULT);
      add_row(OP_INSERT, 32'sd1, 8'd0, 1'b0, NO_RESULT);
      add_row(OP_REMOVE, 32'sd0, 8'd0, 1'b0, NO_RESULT);
      add_row(OP_REMOVE, 32'sd0, 8'd0, 1'b0, NO_RESULT);

      insert_pct = 50;
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 60 == 0) begin
            case ($urandom_range(0, 4))
               0: insert_pct = 10;
               1: insert_pct = 30;
               2: insert_pct = 50;
               3: insert_pct = 70;
               default: insert_pct = 90;
            endcase
         end
         mode = $urandom_range(0, 9);
         if (mode < 5)
            pri = 8'($urandom_range(0, 3));
         else if (mode < 7)
            pri = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         else
            pri = 8'($urandom_range(0, 255));
         add_row(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                 $urandom, pri, 1'b0, NO_RESULT);
      end
   endtask

   initial begin
      int unsigned issued;
      stim_row_type row;
      result_type predicted;
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      issued = 0;
      while (issued < stimulus.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            row = stimulus[issued];
            predicted = queue_step(row.op, row.data, row.pri);
            expected_results.push_back(row.fixed ? row.want : predicted);
            issued++;
         end
         if (!(req_valid && req_stall)) begin
            if (issued < stimulus.size() &&
                ((issued >= CALM_FIRST && issued < CALM_LAST) ||
                 $urandom_range(0, 99) >= STALL_PCT)) begin
               req_valid         <= 1'b1;
               req_operation     <= stimulus[issued].op;
               req_item_data     <= stimulus[issued].data;
               req_item_priority <= stimulus[issued].pri;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("word with nothing expected");
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_status, want.status));
               if (rsp_top_valid !== want.top_valid)
                  report_mismatch($sformatf("top_valid got %0d expected %0d",
                                            rsp_top_valid, want.top_valid));
               if (rsp_top_data !== want.top_data)
                  report_mismatch($sformatf("top_data got %0d expected %0d",
                                            rsp_top_data, want.top_data));
               if (rsp_top_priority !== want.top_priority)
                  report_mismatch($sformatf("top_priority got %0d expected %0d",
                                            rsp_top_priority, want.top_priority));
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count got %0d expected %0d",
                                            rsp_entry_count, want.entry_count));
            end
            words_checked++;
         end
         rsp_stall <= !(words_checked >= CALM_FIRST && words_checked < CALM_LAST) &&
                      ($urandom_range(0, 99) < STALL_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
